// ----- hw/rtl/spgr_pkg.sv -----
// shared constants for the step pulse generator with ramp
package spgr_pkg;

    localparam int unsigned CFG_W     = 16;
    localparam int unsigned CFG_IDX_W = 4;
    localparam int unsigned OUT_SPD_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_STEP = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECEL_STEP = 4'd1;

    localparam logic ACT_PULSE = 1'b0;
    localparam logic ACT_RAMP  = 1'b1;

    localparam logic [CFG_W-1:0] ACCEL_RESET = 16'd1;
    localparam logic [CFG_W-1:0] DECEL_RESET = 16'd1;

endpackage

// ----- hw/rtl/spgr_ramp.sv -----
// one ramp step: move the speed toward the target, limited by accel and decel
module spgr_ramp
    import spgr_pkg::*;
#(
    parameter int unsigned SPEED_WIDTH = 16
) (
    input  logic [SPEED_WIDTH-1:0] i_speed,
    input  logic [SPEED_WIDTH-1:0] i_target,
    input  logic [CFG_W-1:0]       i_accel_step,
    input  logic [CFG_W-1:0]       i_decel_step,
    output logic [SPEED_WIDTH-1:0] o_speed
);

    localparam int unsigned CW = (SPEED_WIDTH > CFG_W) ? SPEED_WIDTH : CFG_W;

    logic            rising;
    logic [CW-1:0]   gap;
    logic [CW-1:0]   accel_ext;
    logic [CW-1:0]   decel_ext;
    logic [CW-1:0]   speed_ext;
    logic [CW-1:0]   stepped;

    always_comb begin
        rising    = (i_speed <= i_target);
        accel_ext = CW'(i_accel_step);
        decel_ext = CW'(i_decel_step);
        speed_ext = CW'(i_speed);
        gap       = rising ? CW'(i_target - i_speed) : CW'(i_speed - i_target);
        // step only while the target is out of reach, so the sum never wraps
        stepped   = rising ? (speed_ext + accel_ext) : (speed_ext - decel_ext);
        if (rising ? (gap > accel_ext) : (gap > decel_ext)) begin
            o_speed = stepped[SPEED_WIDTH-1:0];
        end else begin
            o_speed = i_target;
        end
    end

endmodule

// ----- hw/rtl/step_pulse_generator_with_ramp.sv -----
// step pulse generator: phase accumulator with a linear speed ramp
// throughput: one word per cycle while the output is not stalled; one input register, one result register
// the result register stalls the input register only when both are full
// synchronous active-low reset clears accumulator and speed, accel/decel to 1
module step_pulse_generator_with_ramp
    import spgr_pkg::*;
#(
    parameter int unsigned SPEED_WIDTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic                   i_action,
    input  logic [SPEED_WIDTH-1:0] i_target_speed,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic                   o_step_pulse,
    output logic [OUT_SPD_W-1:0]   o_speed_now,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]       i_cfg_data
);

    localparam int unsigned CW = (SPEED_WIDTH > OUT_SPD_W) ? SPEED_WIDTH : OUT_SPD_W;

    logic [CFG_W-1:0]       r_accel_step;
    logic [CFG_W-1:0]       r_decel_step;
    logic [SPEED_WIDTH-1:0] r_phase_acc;
    logic [SPEED_WIDTH-1:0] r_speed;

    logic                   r_s1_valid;
    logic                   r_s1_action;
    logic [SPEED_WIDTH-1:0] r_s1_target;

    logic                   r_out_valid;
    logic                   r_out_pulse;
    logic [OUT_SPD_W-1:0]   r_out_speed;

    logic                   advance;
    logic [SPEED_WIDTH:0]   acc_sum;
    logic [SPEED_WIDTH-1:0] ramp_speed;
    logic [SPEED_WIDTH-1:0] n_speed;
    logic [SPEED_WIDTH-1:0] n_phase_acc;
    logic                   n_pulse;
    logic [CW-1:0]          speed_ext;

    assign o_cfg_ready = 1'b1;
    assign advance     = !r_out_valid || i_out_ready;
    assign o_in_ready  = advance || !r_s1_valid;
    assign o_out_valid = r_out_valid;
    assign o_step_pulse = r_out_pulse;
    assign o_speed_now  = r_out_speed;

    spgr_ramp #(
        .SPEED_WIDTH (SPEED_WIDTH)
    ) u_ramp (
        .i_speed      (r_speed),
        .i_target     (r_s1_target),
        .i_accel_step (r_accel_step),
        .i_decel_step (r_decel_step),
        .o_speed      (ramp_speed)
    );

    always_comb begin
        acc_sum     = {1'b0, r_phase_acc} + {1'b0, r_speed};
        n_speed     = r_speed;
        n_phase_acc = r_phase_acc;
        n_pulse     = 1'b0;
        case (r_s1_action)
            ACT_PULSE: begin
                n_phase_acc = acc_sum[SPEED_WIDTH-1:0];
                n_pulse     = acc_sum[SPEED_WIDTH];
            end
            ACT_RAMP: begin
                n_speed = ramp_speed;
            end
            default: begin
                n_speed = r_speed;
            end
        endcase
        speed_ext = CW'(n_speed);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel_step <= ACCEL_RESET;
            r_decel_step <= DECEL_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_ACCEL_STEP: r_accel_step <= i_cfg_data;
                REG_DECEL_STEP: r_decel_step <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1_action <= i_action;
            r_s1_target <= i_target_speed;
        end
    end

    // state update and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_phase_acc <= '0;
            r_speed     <= '0;
        end else if (advance) begin
            r_out_valid <= r_s1_valid;
            if (r_s1_valid) begin
                r_phase_acc <= n_phase_acc;
                r_speed     <= n_speed;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_s1_valid) begin
            r_out_pulse <= n_pulse;
            r_out_speed <= speed_ext[OUT_SPD_W-1:0];
        end
    end

endmodule

// ----- dv/step_pulse_checker.sv -----
`timescale 1ns / 100ps
// checker for the step pulse generator: predicts each result word and compares it
module step_pulse_checker
    import spgr_pkg::*;
#(
    parameter int unsigned SPD_W = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic                 i_action,
    input  logic [SPD_W-1:0]     i_target_speed,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic                 i_step_pulse,
    input  logic [OUT_SPD_W-1:0] i_speed_now,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output int                   o_err_count,
    output int                   o_pending
);

    typedef struct packed {
        logic                 pulse;
        logic [OUT_SPD_W-1:0] speed;
    } t_step_word;

    t_step_word       predicted_steps[$];
    logic [CFG_W-1:0] accel_step;
    logic [CFG_W-1:0] decel_step;
    logic [SPD_W-1:0] phase_acc;
    logic [SPD_W-1:0] cur_speed;
    int               err_count = 0;

    // move speed toward target, limited by the up/down step, landing on target
    function automatic logic [SPD_W-1:0] ramp_speed(input logic [SPD_W-1:0] speed,
                                                    input logic [SPD_W-1:0] target,
                                                    input logic [CFG_W-1:0] up,
                                                    input logic [CFG_W-1:0] down);
        if (speed <= target) begin
            if ((target - speed) > up)
                return speed + up;
            return target;
        end
        if ((speed - target) > down)
            return speed - down;
        return target;
    endfunction

    task automatic report_mismatch(input string what, input int want, input int got);
        if (err_count < 10)
            $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
        err_count++;
    endtask

    always @(posedge i_clk) begin
        logic [SPD_W:0] sum;
        t_step_word     want;
        logic           pulse;
        if (!i_rst_n) begin
            accel_step = ACCEL_RESET;
            decel_step = DECEL_RESET;
            phase_acc  = '0;
            cur_speed  = '0;
            predicted_steps.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_ACCEL_STEP: accel_step = i_cfg_data;
                    REG_DECEL_STEP: decel_step = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                pulse = 1'b0;
                if (i_action == ACT_PULSE) begin
                    sum       = {1'b0, phase_acc} + {1'b0, cur_speed};
                    pulse     = sum[SPD_W];
                    phase_acc = sum[SPD_W-1:0];
                end else begin
                    cur_speed = ramp_speed(cur_speed, i_target_speed, accel_step, decel_step);
                end
                want.pulse = pulse;
                want.speed = OUT_SPD_W'(cur_speed);
                predicted_steps.push_back(want);
            end
            if (i_out_valid && i_out_ready) begin
                if (predicted_steps.size() == 0) begin
                    report_mismatch("unexpected result word, pending", 0, 1);
                end else begin
                    want = predicted_steps.pop_front();
                    if (i_step_pulse !== want.pulse)
                        report_mismatch("step_pulse", want.pulse, i_step_pulse);
                    if (i_speed_now !== want.speed)
                        report_mismatch("speed_now", want.speed, i_speed_now);
                end
            end
        end
        o_pending   <= predicted_steps.size();
        o_err_count <= err_count;
    end

endmodule

// ----- dv/step_pulse_generator_with_ramp_tb.sv -----
`timescale 1ns / 100ps
// testbench top for the step pulse generator: stimulus, flow control and verdict
module step_pulse_generator_with_ramp_tb;
    import spgr_pkg::*;

    localparam int unsigned SPD_W       = 16;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          PHASES      = 15;
    localparam int          PHASE_WORDS = 50;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_action = ACT_PULSE;
    logic [SPD_W-1:0]     in_target = '0;
    logic                 out_ready = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 in_ready;
    logic                 out_valid;
    logic                 step_pulse;
    logic [OUT_SPD_W-1:0] speed_now;
    logic                 cfg_ready;
    int                   err_count;
    int                   pending;
    int                   src_idle_pct = 38;
    int                   sink_idle_pct = 84;
    int                   cycles = 0;

    step_pulse_generator_with_ramp #(
        .SPEED_WIDTH(SPD_W)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_action       (in_action),
        .i_target_speed (in_target),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_step_pulse   (step_pulse),
        .o_speed_now    (speed_now),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    step_pulse_checker #(
        .SPD_W(SPD_W)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_action       (in_action),
        .i_target_speed (in_target),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_step_pulse   (step_pulse),
        .i_speed_now    (speed_now),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_err_count    (err_count),
        .o_pending      (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        out_ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("step_pulse_generator_with_ramp_tb: FAIL");
            $finish;
        end
    end

    // valid stays high after acceptance so back-to-back words need no toggle
    task automatic send_word(input logic act, input logic [SPD_W-1:0] tgt);
        while ($urandom_range(99) < src_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid  <= 1'b1;
        in_action <= act;
        in_target <= tgt;
        do @(posedge i_clk); while (!in_ready);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        // let the pending count catch up with the last accepted word
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    function automatic logic [SPD_W-1:0] pick_target();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return SPD_W'($urandom_range(1023));
            default: return SPD_W'($urandom);
        endcase
    endfunction

    initial begin
        logic [CFG_W-1:0] acc_val;
        logic [CFG_W-1:0] dec_val;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset step sizes of one, speed starts at zero
        send_word(ACT_PULSE, '1);
        send_word(ACT_RAMP, '1);
        send_word(ACT_RAMP, '0);
        send_word(ACT_RAMP, '0);
        wait_idle();

        write_reg(REG_ACCEL_STEP, '1);
        write_reg(REG_DECEL_STEP, '1);
        write_reg(CFG_IDX_W'(7), 16'h1234);
        write_reg('1, 16'h0000);
        send_word(ACT_RAMP, '1);
        send_word(ACT_PULSE, '0);
        send_word(ACT_PULSE, '1);
        send_word(ACT_PULSE, '0);
        send_word(ACT_RAMP, '0);
        send_word(ACT_RAMP, 16'h8000);
        send_word(ACT_PULSE, '0);
        send_word(ACT_PULSE, '0);
        wait_idle();

        // zero step sizes: speed never moves, as a step of zero leaves it where it is
        write_reg(REG_ACCEL_STEP, '0);
        write_reg(REG_DECEL_STEP, '0);
        send_word(ACT_RAMP, '1);
        send_word(ACT_RAMP, 16'h8000);
        send_word(ACT_RAMP, '0);
        send_word(ACT_PULSE, '0);
        wait_idle();

        write_reg(REG_ACCEL_STEP, 16'd3);
        write_reg(REG_DECEL_STEP, 16'd5);
        send_word(ACT_RAMP, 16'd10);
        send_word(ACT_RAMP, 16'h8003);
        send_word(ACT_RAMP, 16'h8004);
        send_word(ACT_PULSE, '1);
        wait_idle();

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph / 5)
                0: begin
                    src_idle_pct  = 38;
                    sink_idle_pct = 84;
                end
                1: begin
                    src_idle_pct  = 84;
                    sink_idle_pct = 38;
                end
                default: begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            case (ph % 5)
                0: begin
                    acc_val = '1;
                    dec_val = '1;
                end
                1: begin
                    acc_val = CFG_W'($urandom_range(1, 64));
                    dec_val = '0;
                end
                2: begin
                    acc_val = CFG_W'($urandom);
                    dec_val = CFG_W'($urandom);
                end
                3: begin
                    acc_val = 16'd1;
                    dec_val = 16'd1;
                end
                default: begin
                    acc_val = '0;
                    dec_val = CFG_W'($urandom_range(256, 4096));
                end
            endcase
            write_reg(REG_ACCEL_STEP, acc_val);
            write_reg(REG_DECEL_STEP, dec_val);
            if ($urandom_range(2) == 0)
                write_reg(CFG_IDX_W'($urandom_range(2, 15)), CFG_W'($urandom));
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if ($urandom_range(99) < 35)
                    send_word(ACT_RAMP, pick_target());
                else
                    send_word(ACT_PULSE, SPD_W'($urandom));
            end
            wait_idle();
        end

        repeat (10) @(posedge i_clk);
        if (err_count == 0 && pending == 0) begin
            $display("step_pulse_generator_with_ramp_tb: PASS");
        end else begin
            $display("step_pulse_generator_with_ramp_tb: FAIL");
        end
        $finish;
    end

endmodule
